// ===== rtl/heu_pkg.sv =====
// ----------------------------------------------------------------------------
// heu_pkg
// Shared types, constants and entity tables for the html escape encoder.
// ----------------------------------------------------------------------------
package heu_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        K_PLAIN  = 3'd0,
        K_QUOT   = 3'd1,
        K_DOLLAR = 3'd2,
        K_AMP    = 3'd3,
        K_LT     = 3'd4,
        K_GT     = 3'd5,
        K_PIC    = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] PIC_DEL   = 8'h21;

    localparam logic [63:0] ENT_QUOT   = {"&quot;", 16'h0000};
    localparam logic [63:0] ENT_DOLLAR = {"&#36;", 24'h000000};
    localparam logic [63:0] ENT_AMP    = {"&amp;", 24'h000000};
    localparam logic [63:0] ENT_LT     = {"&lt;", 32'h00000000};
    localparam logic [63:0] ENT_GT     = {"&gt;", 32'h00000000};
    localparam logic [39:0] ENT_PIC    = "&#x24";

    function automatic t_kind classify(input logic [7:0] b);
        t_kind k;
        k = K_PLAIN;
        if ((b <= 8'h1F && b != CH_TAB && b != CH_LF && b != CH_CR) || b == CH_DEL) begin
            k = K_PIC;
        end else begin
            case (b)
                CH_DQUOTE: k = K_QUOT;
                CH_DOLLAR: k = K_DOLLAR;
                CH_AMP:    k = K_AMP;
                CH_LT:     k = K_LT;
                CH_GT:     k = K_GT;
                default:   k = K_PLAIN;
            endcase
        end
        return k;
    endfunction

    function automatic logic [3:0] esc_len(input t_kind k);
        logic [3:0] n;
        case (k)
            K_QUOT:   n = 4'd6;
            K_DOLLAR: n = 4'd5;
            K_AMP:    n = 4'd5;
            K_LT:     n = 4'd4;
            K_GT:     n = 4'd4;
            K_PIC:    n = 4'd8;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'h0, v};
        end else begin
            c = 8'h37 + {4'h0, v};
        end
        return c;
    endfunction

    function automatic logic [7:0] esc_char(input t_kind k, input logic [7:0] b,
                                            input logic [2:0] idx);
        logic [63:0] w;
        logic [7:0]  code;
        code = (b == CH_DEL) ? PIC_DEL : b;
        case (k)
            K_QUOT:   w = ENT_QUOT;
            K_DOLLAR: w = ENT_DOLLAR;
            K_AMP:    w = ENT_AMP;
            K_LT:     w = ENT_LT;
            K_GT:     w = ENT_GT;
            K_PIC:    w = {ENT_PIC, hex_upper(code[7:4]), hex_upper(code[3:0]), ";"};
            default:  w = {b, 56'h0};
        endcase
        return w[(3'd7 - idx) * 8 +: 8];
    endfunction

endpackage

// ===== rtl/heu_front.sv =====
// ----------------------------------------------------------------------------
// heu_front
// Accepts input items and registers them with their escape class.
// ----------------------------------------------------------------------------
module heu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_in_byte,
    input  logic              i_message_last,
    input  heu_pkg::t_qstat   i_qstat,
    output logic              o_qpush,
    output heu_pkg::t_item    o_item
);

    logic           r_valid;
    heu_pkg::t_item r_item;
    logic           w_take;

    assign full    = r_valid && i_qstat.full;
    assign w_take  = push && !full;
    assign o_qpush = r_valid && !i_qstat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_qpush) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind <= heu_pkg::classify(i_in_byte);
            r_item.data <= i_in_byte;
            r_item.last <= i_message_last;
        end
    end

endmodule

// ===== rtl/heu_queue.sv =====
// ----------------------------------------------------------------------------
// heu_queue
// Short show-ahead queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module heu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  heu_pkg::t_item    i_item,
    input  logic              i_pop,
    output heu_pkg::t_item    o_head,
    output heu_pkg::t_qstat   o_stat
);

    heu_pkg::t_item              r_mem [heu_pkg::QDEPTH];
    logic [heu_pkg::QAW:0]       r_wp;
    logic [heu_pkg::QAW:0]       r_rp;

    assign o_stat.empty = (r_wp == r_rp);
    assign o_stat.full  = (r_wp[heu_pkg::QAW] != r_rp[heu_pkg::QAW])
                       && (r_wp[heu_pkg::QAW-1:0] == r_rp[heu_pkg::QAW-1:0]);
    assign o_head       = r_mem[r_rp[heu_pkg::QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[heu_pkg::QAW-1:0]] <= i_item;
        end
    end

endmodule

// ===== rtl/heu_back.sv =====
// ----------------------------------------------------------------------------
// heu_back
// Expands the queue head into its run of output bytes, one per cycle while results are popped.
// ----------------------------------------------------------------------------
module heu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  heu_pkg::t_item    i_head,
    input  heu_pkg::t_qstat   i_qstat,
    output logic              o_qpop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_message_end
);

    logic [2:0] r_k;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_rl;
    logic       r_me;
    logic       w_adv;
    logic       w_last_k;
    logic [3:0] w_len;

    assign w_len    = heu_pkg::esc_len(i_head.kind);
    assign w_last_k = ({1'b0, r_k} == (w_len - 4'd1));
    assign w_adv    = !i_qstat.empty && (!r_ov || pop);
    assign o_qpop   = w_adv && w_last_k;

    assign empty         = !r_ov;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_rl;
    assign o_message_end = r_me;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_k  <= '0;
        end else if (w_adv) begin
            r_ov <= 1'b1;
            r_k  <= w_last_k ? 3'd0 : r_k + 3'd1;
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_byte <= heu_pkg::esc_char(i_head.kind, i_head.data, r_k);
            r_rl   <= w_last_k;
            r_me   <= w_last_k && i_head.last;
        end
    end

endmodule

// ===== rtl/html_escape_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// html_escape_encoder_unit
// HTML entity escaper: one text byte in, a run of escaped bytes out.
// ----------------------------------------------------------------------------
// A byte that passes unchanged yields a single result byte, so plain text streams
// at one item per cycle while results are popped; an escaped byte yields a run of
// 4 to 8 result bytes, one result per cycle while results are popped, and holds the
// serializer for the whole run, while the front keeps taking items into a four-entry
// queue. A pushed byte passes the classify register, queue and output register in turn.
module html_escape_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_message_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_message_end
);

    heu_pkg::t_item  w_fitem;
    heu_pkg::t_item  w_head;
    heu_pkg::t_qstat w_qstat;
    logic            w_qpush;
    logic            w_qpop;

    heu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_message_last (i_message_last),
        .i_qstat        (w_qstat),
        .o_qpush        (w_qpush),
        .o_item         (w_fitem)
    );

    heu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_item  (w_fitem),
        .i_pop   (w_qpop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    heu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_qstat       (w_qstat),
        .o_qpop        (w_qpop),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

endmodule

// ===== rtl/heu_checker.sv =====
// ----------------------------------------------------------------------------
// heu_checker
// Port-level checks on the escaper's reset state and result stream.
// ----------------------------------------------------------------------------
module heu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_out_byte,
    input  logic        o_run_last,
    input  logic        o_message_end
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_run_last)
                           && $stable(o_message_end))
        else $error("stalled item changed");

    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_message_end |-> o_run_last)
        else $error("message end off a run boundary");

    a_semi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_byte == 8'h3B |-> o_run_last)
        else $error("semicolon inside a run");

endmodule

bind html_escape_encoder_unit heu_checker u_heu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_out_byte     (o_out_byte),
    .o_run_last     (o_run_last),
    .o_message_end  (o_message_end)
);
